### rtl/masked_descending_table_search_top_defines.svh
// Assertion macros for the masked descending table search.
// Expects clk and rst in the scope of each use.
`ifndef MASKED_DESCENDING_TABLE_SEARCH_TOP_DEFINES_SVH
`define MASKED_DESCENDING_TABLE_SEARCH_TOP_DEFINES_SVH

// same-cycle implication
`define MDTS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define MDTS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/mdts_pkg.sv
// Shared constants, types and compare function for the table search.
// No dependencies.
package mdts_pkg;

  localparam int TABLE_DEPTH = 1024;
  localparam int ADDR_W      = $clog2(TABLE_DEPTH);
  localparam int LEN_W       = ADDR_W + 1;
  localparam int KEY_W       = 64;
  localparam int CFG_IDX_W   = 4;

  localparam logic [CFG_IDX_W-1:0] REG_COMPARE_MASK   = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_ENTRIES_IN_USE = CFG_IDX_W'(1);

  localparam logic REQ_WRITE = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  typedef struct packed {
    logic [KEY_W-1:0] mask;
    logic [LEN_W-1:0] len;
  } cfg_t;

  function automatic logic masked_gt(input logic [KEY_W-1:0] a,
                                     input logic [KEY_W-1:0] b,
                                     input logic [KEY_W-1:0] mask);
    return (a ^ mask) > (b ^ mask);
  endfunction

endpackage

### rtl/mdts_channels.sv
// Handshake channels of the table search: request, result, register write.
// Depends on mdts_pkg.
interface mdts_req_if;
  logic                       valid;
  logic                       ready;
  logic                       req_type;
  logic [mdts_pkg::ADDR_W-1:0] entry_position;
  logic [mdts_pkg::KEY_W-1:0]  key_value;

  modport source (output valid, req_type, entry_position, key_value, input ready);
  modport sink   (input valid, req_type, entry_position, key_value, output ready);
endinterface

interface mdts_res_if;
  logic                       valid;
  logic                       ready;
  logic                       key_found;
  logic [mdts_pkg::LEN_W-1:0] result_position;

  modport source (output valid, key_found, result_position, input ready);
  modport sink   (input valid, key_found, result_position, output ready);
endinterface

interface mdts_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [mdts_pkg::CFG_IDX_W-1:0] index;
  logic [mdts_pkg::KEY_W-1:0]     data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

### rtl/mdts_key_ram.sv
// Key table: one write port, one read port, registered read data.
// Depends on mdts_pkg.
module mdts_key_ram (
  input  logic                        clk,
  input  logic                        we,
  input  logic [mdts_pkg::ADDR_W-1:0] waddr,
  input  logic [mdts_pkg::KEY_W-1:0]  wdata,
  input  logic                        re,
  input  logic [mdts_pkg::ADDR_W-1:0] raddr,
  output logic [mdts_pkg::KEY_W-1:0]  rdata
);

  logic [mdts_pkg::KEY_W-1:0] mem [mdts_pkg::TABLE_DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### rtl/mdts_cfg_regs.sv
// Register file: compare mask and entry count (count clamped to table depth).
// Depends on mdts_pkg and mdts_channels.
module mdts_cfg_regs (
  input  logic             clk,
  input  logic             rst,
  mdts_cfg_if.sink         cfg,
  output mdts_pkg::cfg_t   cfg_q
);

  logic [mdts_pkg::LEN_W-1:0] len_wr;

  assign cfg.ready = 1'b1;

  always_comb begin
    len_wr = cfg.data[mdts_pkg::LEN_W-1:0];
    if (len_wr > mdts_pkg::LEN_W'(mdts_pkg::TABLE_DEPTH)) begin
      len_wr = mdts_pkg::LEN_W'(mdts_pkg::TABLE_DEPTH);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_q <= '0;
    end else if (cfg.valid && cfg.ready) begin
      case (cfg.index)
        mdts_pkg::REG_COMPARE_MASK:   cfg_q.mask <= cfg.data;
        mdts_pkg::REG_ENTRIES_IN_USE: cfg_q.len  <= len_wr;
        default: ;
      endcase
    end
  end

endmodule

### rtl/mdts_search_fsm.sv
// Search sequencer: first-entry check, halving probes, final equality check,
// result register. Depends on mdts_pkg and mdts_channels.
module mdts_search_fsm (
  input  logic                        clk,
  input  logic                        rst,
  input  mdts_pkg::cfg_t              cfg_q,
  mdts_req_if.sink                    req,
  mdts_res_if.source                  res,
  input  logic [mdts_pkg::KEY_W-1:0]  rd_data,
  output logic                        rd_en,
  output logic [mdts_pkg::ADDR_W-1:0] rd_addr
);

  typedef enum logic [2:0] {ST_IDLE, ST_FIRST, ST_PROBE, ST_FINAL, ST_DONE} state_t;

  state_t                      state;
  logic [mdts_pkg::KEY_W-1:0]  key;
  logic [mdts_pkg::LEN_W-1:0]  n;
  logic [mdts_pkg::ADDR_W-1:0] i;
  logic                        found_r;
  logic [mdts_pkg::LEN_W-1:0]  where_r;
  logic                        res_valid;
  logic                        res_found;
  logic [mdts_pkg::LEN_W-1:0]  res_pos;

  logic                        query_acc;
  logic                        probe_gt;
  logic                        hit;
  logic [mdts_pkg::LEN_W-1:0]  half;
  logic [mdts_pkg::LEN_W-1:0]  n_next;
  logic [mdts_pkg::ADDR_W-1:0] i_next;
  logic [mdts_pkg::LEN_W-1:0]  half_next;
  logic [mdts_pkg::LEN_W-1:0]  first_half;

  assign req.ready           = (state == ST_IDLE);
  assign res.valid           = res_valid;
  assign res.key_found       = res_found;
  assign res.result_position = res_pos;

  assign query_acc = req.valid && req.ready && (req.req_type == mdts_pkg::REQ_QUERY);

  always_comb begin
    probe_gt   = mdts_pkg::masked_gt(key, rd_data, cfg_q.mask);
    hit        = (rd_data == key);
    half       = n >> 1;
    n_next     = probe_gt ? half : n - half;
    i_next     = probe_gt ? i : i + half[mdts_pkg::ADDR_W-1:0];
    half_next  = n_next >> 1;
    first_half = cfg_q.len >> 1;
    rd_en      = 1'b0;
    rd_addr    = '0;
    case (state)
      ST_IDLE: begin
        if (query_acc && cfg_q.len != '0) begin
          rd_en = 1'b1;
        end
      end
      ST_FIRST: begin
        if (!probe_gt && cfg_q.len > mdts_pkg::LEN_W'(1)) begin
          rd_en   = 1'b1;
          rd_addr = first_half[mdts_pkg::ADDR_W-1:0];
        end
      end
      ST_PROBE: begin
        rd_en = 1'b1;
        if (n_next > mdts_pkg::LEN_W'(1)) begin
          rd_addr = i_next + half_next[mdts_pkg::ADDR_W-1:0];
        end else begin
          rd_addr = i_next;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      res_valid <= 1'b0;
    end else begin
      if (res_valid && res.ready && state != ST_DONE) begin
        res_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (query_acc) begin
            key <= req.key_value;
            if (cfg_q.len == '0) begin
              found_r <= 1'b0;
              where_r <= '0;
              state   <= ST_DONE;
            end else begin
              state <= ST_FIRST;
            end
          end
        end
        ST_FIRST: begin
          if (probe_gt) begin
            found_r <= 1'b0;
            where_r <= '0;
            state   <= ST_DONE;
          end else if (cfg_q.len > mdts_pkg::LEN_W'(1)) begin
            n     <= cfg_q.len;
            i     <= '0;
            state <= ST_PROBE;
          end else begin
            found_r <= hit;
            where_r <= hit ? mdts_pkg::LEN_W'(0) : mdts_pkg::LEN_W'(1);
            state   <= ST_DONE;
          end
        end
        ST_PROBE: begin
          n <= n_next;
          i <= i_next;
          if (n_next <= mdts_pkg::LEN_W'(1)) begin
            state <= ST_FINAL;
          end
        end
        ST_FINAL: begin
          found_r <= hit;
          where_r <= hit ? {1'b0, i} : {1'b0, i} + mdts_pkg::LEN_W'(1);
          state   <= ST_DONE;
        end
        ST_DONE: begin
          if (!res_valid || res.ready) begin
            res_valid <= 1'b1;
            res_found <= found_r;
            res_pos   <= where_r;
            state     <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

### rtl/masked_descending_table_search_top.sv
// Channel   Dir  Fields
// req       in   req_type, entry_position, key_value
// res       out  key_found, result_position
// cfg       in   index, data (0 compare_mask, 1 entries_in_use)
//
// A write request goes straight to the key RAM and leaves the sequencer idle. A query over
// more than one entry halves its range with each probe, bound by the single read port of the
// key RAM: one probe a cycle. An empty table finishes without a RAM read; a key above entry 0
// or a one-entry table finishes after the first-entry check.
// Synchronous reset clears control and registers; table contents stay unknown.
// A result waiting on res holds the sequencer in its last state only.
// Depends on mdts_pkg, mdts_channels, mdts_key_ram, mdts_cfg_regs, mdts_search_fsm.
`include "masked_descending_table_search_top_defines.svh"

module masked_descending_table_search_top (
  input  logic        clk,
  input  logic        rst,
  mdts_req_if.sink    req,
  mdts_res_if.source  res,
  mdts_cfg_if.sink    cfg
);

  mdts_pkg::cfg_t              cfg_q;
  logic                        rd_en;
  logic [mdts_pkg::ADDR_W-1:0] rd_addr;
  logic [mdts_pkg::KEY_W-1:0]  rd_data;
  logic                        wr_en;

  assign wr_en = req.valid && req.ready && (req.req_type == mdts_pkg::REQ_WRITE);

  mdts_cfg_regs u_cfg (
    .clk   (clk),
    .rst   (rst),
    .cfg   (cfg),
    .cfg_q (cfg_q)
  );

  mdts_key_ram u_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (req.entry_position),
    .wdata (req.key_value),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  mdts_search_fsm u_fsm (
    .clk     (clk),
    .rst     (rst),
    .cfg_q   (cfg_q),
    .req     (req),
    .res     (res),
    .rd_data (rd_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr)
  );

  `MDTS_ASSERT_NOW(a_pos_in_range, res.valid,
                   res.result_position <= cfg_q.len, "position beyond length")
  `MDTS_ASSERT_NOW(a_found_inside, res.valid && res.key_found,
                   res.result_position < cfg_q.len, "match outside table")
  `MDTS_ASSERT_NEXT(a_write_silent, wr_en && !res.valid, !res.valid,
                    "write produced a result")
  `MDTS_ASSERT_NEXT(a_query_busy,
                    req.valid && req.ready && req.req_type == mdts_pkg::REQ_QUERY,
                    !req.ready, "query not held")

endmodule
